[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the morph weight block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted.
`define MWE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define MWE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mwe_pkg.sv]
// ----------------------------------------------------------------------------
// mwe_pkg
// Types, constants and helpers shared by the morph weight easing block.
// ----------------------------------------------------------------------------
package mwe_pkg;

	localparam int MAX_FRAMES = 1024;
	localparam logic [24:0] ONE_Q24 = 25'd16777216;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	localparam logic [7:0] CFG_CLIP_LOADED = 8'd0;
	localparam logic [7:0] CFG_FRAME_COUNT = 8'd1;

	// Quotient bits of the divider and bits resolved per stage.
	localparam int DIV_BITS = 40;
	localparam int DIV_STEP = 4;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

	// Series terms of the cosine and resulting pipeline depth.
	localparam int COS_TERMS = 6;
	localparam int COS_STAGES = 3 + 3 * COS_TERMS + 1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOCLIP  = 2'd1,
		ST_ZERODUR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CRV_NONE  = 2'd0,
		CRV_TINY  = 2'd1,
		CRV_LEAD  = 2'd2,
		CRV_TRAIL = 2'd3
	} curve_t;

	typedef struct packed {
		status_t status;
		curve_t  curve;
		logic    rev;
		logic    off_neg;
	} meta_t;

	typedef struct packed {
		meta_t       meta;
		logic [15:0] phase;
		logic [15:0] dur;
		logic [23:0] mag;
	} div_in_t;

	typedef struct packed {
		meta_t              meta;
		logic [39:0]        v;
		logic signed [32:0] o;
	} item_t;

	function automatic logic [31:0] sat32(input logic signed [43:0] x);
		if (x > 44'sd2147483647)
			return 32'h7fff_ffff;
		else if (x < -44'sd2147483648)
			return 32'h8000_0000;
		else
			return x[31:0];
	endfunction

endpackage

[rtl/mwe_if.sv]
// ----------------------------------------------------------------------------
// mwe_if
// Valid/ready channels of the morph weight block: requests, results, config.
// ----------------------------------------------------------------------------
interface mwe_req_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] from_frame;
	logic signed [10:0] to_frame;
	logic [15:0]        phase;
	logic [15:0]        segment_duration;
	logic signed [23:0] offset;
	logic               ease_on;
	logic               reverse_dir;

	modport source (output valid, from_frame, to_frame, phase, segment_duration,
		offset, ease_on, reverse_dir, input ready);
	modport sink (input valid, from_frame, to_frame, phase, segment_duration,
		offset, ease_on, reverse_dir, output ready);
endinterface

interface mwe_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] weight_from;
	logic signed [31:0] weight_to;
	logic [1:0]         curve_used;
	logic [1:0]         status;

	modport source (output valid, weight_from, weight_to, curve_used, status,
		input ready);
	modport sink (input valid, weight_from, weight_to, curve_used, status,
		output ready);
endinterface

interface mwe_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [10:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/mwe_front.sv]
// ----------------------------------------------------------------------------
// mwe_front
// Configuration registers, request checks and curve selection.
// ----------------------------------------------------------------------------
module mwe_front import mwe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	mwe_req_if.sink  req,
	mwe_cfg_if.sink  cfg,
	output logic     vld_s1,
	output div_in_t  din_s1
);

	logic               clip_q;
	logic [10:0]        fc_q;
	logic [10:0]        fc;
	logic signed [12:0] fc13, from13, to13, lead;
	status_t            status;
	curve_t             curve;
	div_in_t            din;

	assign cfg.ready = 1'b1;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
			fc_q   <= 11'd0;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_CLIP_LOADED)
				clip_q <= cfg.data[0];
			else if (cfg.index == CFG_FRAME_COUNT)
				fc_q <= cfg.data;
		end
	end

	always_comb begin
		fc     = (32'(fc_q) > MAX_FRAMES) ? 11'(MAX_FRAMES) : fc_q;
		fc13   = signed'({2'b00, fc});
		from13 = 13'(req.from_frame);
		to13   = 13'(req.to_frame);
		lead   = req.reverse_dir ? to13 : from13;

		if (!clip_q || fc == 11'd0 || lead < 13'sd0 || lead >= fc13)
			status = ST_NOCLIP;
		else if (req.segment_duration == 16'd0)
			status = ST_ZERODUR;
		else
			status = ST_OK;

		curve = CRV_NONE;
		if (req.ease_on) begin
			if (req.reverse_dir) begin
				if (fc13 <= 13'sd2 && to13 <= 13'sd0)
					curve = CRV_TINY;
				else if (to13 <= 13'sd0)
					curve = CRV_LEAD;
				else if (fc13 - 13'sd1 <= from13)
					curve = CRV_TRAIL;
			end else begin
				if (fc13 <= 13'sd2 && from13 + 13'sd1 >= fc13 - 13'sd1)
					curve = CRV_TINY;
				else if (fc13 - 13'sd1 <= to13)
					curve = CRV_TRAIL;
				else if (from13 <= 13'sd0)
					curve = CRV_LEAD;
			end
		end

		din.meta.status  = status;
		din.meta.curve   = curve;
		din.meta.rev     = req.reverse_dir;
		din.meta.off_neg = req.offset[23];
		din.phase        = req.phase;
		din.dur          = req.segment_duration;
		din.mag          = req.offset[23] ? 24'(-req.offset) : req.offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			din_s1 <= din;
	end

endmodule

[rtl/mwe_div.sv]
// ----------------------------------------------------------------------------
// mwe_div
// Pipelined restoring divider with two lanes sharing one divisor:
// phase * 2^24 / duration and |offset| * 2^8 / duration.
// ----------------------------------------------------------------------------
module mwe_div import mwe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  div_in_t     din,
	output logic        out_vld,
	output meta_t       out_meta,
	output logic [39:0] out_q1,
	output logic [31:0] out_q2
);

	typedef struct packed {
		logic [15:0]         rem;
		logic [DIV_BITS-1:0] nq;
	} lane_t;

	// Numerator bits shift out of the top of nq, quotient bits in at the bottom.
	function automatic lane_t div_steps(input lane_t l, input logic [15:0] d);
		lane_t       r;
		logic [16:0] sh;
		r = l;
		for (int b = 0; b < DIV_STEP; b++) begin
			sh   = {r.rem, r.nq[DIV_BITS-1]};
			r.nq = {r.nq[DIV_BITS-2:0], 1'b0};
			if (sh >= {1'b0, d}) begin
				r.rem   = 16'(sh - {1'b0, d});
				r.nq[0] = 1'b1;
			end else begin
				r.rem = sh[15:0];
			end
		end
		return r;
	endfunction

	logic        vld_s  [DIV_STAGES];
	meta_t       meta_s [DIV_STAGES];
	logic [15:0] d_s    [DIV_STAGES];
	lane_t       l1_s   [DIV_STAGES];
	lane_t       l2_s   [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic        vld_in;
		meta_t       meta_in;
		logic [15:0] d_in;
		lane_t       l1_in, l2_in;

		if (j == 0) begin : g_first
			assign vld_in    = in_vld;
			assign meta_in   = din.meta;
			assign d_in      = din.dur;
			assign l1_in.rem = 16'd0;
			assign l1_in.nq  = {din.phase, 24'd0};
			assign l2_in.rem = 16'd0;
			assign l2_in.nq  = {8'd0, din.mag, 8'd0};
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign meta_in = meta_s[j-1];
			assign d_in    = d_s[j-1];
			assign l1_in   = l1_s[j-1];
			assign l2_in   = l2_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j] <= 1'b0;
			else if (en)
				vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[j] <= meta_in;
				d_s[j]    <= d_in;
				l1_s[j]   <= div_steps(l1_in, d_in);
				l2_s[j]   <= div_steps(l2_in, d_in);
			end
		end
	end

	assign out_vld  = vld_s[DIV_STAGES-1];
	assign out_meta = meta_s[DIV_STAGES-1];
	assign out_q1   = l1_s[DIV_STAGES-1].nq;
	assign out_q2   = l2_s[DIV_STAGES-1].nq[31:0];

endmodule

[rtl/mwe_cos.sv]
// ----------------------------------------------------------------------------
// mwe_cos
// Angle folding and a pipelined Taylor series cosine in quarter turns.
// Each series term takes three stages: product, reciprocal, correction.
// ----------------------------------------------------------------------------
module mwe_cos import mwe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  meta_t              in_meta,
	input  logic [39:0]        in_q1,
	input  logic [31:0]        in_q2,
	output logic               out_vld,
	output item_t              out_item,
	output logic signed [25:0] out_c
);

	logic  vld_s  [COS_STAGES];
	item_t item_s [COS_STAGES];
	logic  neg_s  [COS_STAGES];

	item_t       item_in;
	logic [25:0] ang;
	logic [24:0] x;
	logic        neg;

	always_comb begin
		item_in.meta = in_meta;
		item_in.v    = in_q1;
		item_in.o    = in_meta.off_neg ? -signed'({1'b0, in_q2}) : signed'({1'b0, in_q2});
		case (in_meta.curve)
			CRV_TINY:  ang = {in_q1[24:0], 1'b0};
			CRV_TRAIL: ang = in_q1[25:0] + 26'(ONE_Q24);
			default:   ang = in_q1[25:0];
		endcase
		// Odd quadrants mirror the fraction; the middle two flip the sign.
		x   = ang[24] ? ONE_Q24 - {1'b0, ang[23:0]} : {1'b0, ang[23:0]};
		neg = ang[25] ^ ang[24];
	end

	// Sideband shift line that runs alongside the arithmetic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COS_STAGES; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < COS_STAGES; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= item_in;
			neg_s[0]  <= neg;
			for (int i = 1; i < COS_STAGES; i++) begin
				item_s[i] <= item_s[i-1];
				neg_s[i]  <= neg_s[i-1];
			end
		end
	end

	logic [24:0] x_s1;
	logic [30:0] u_s2;
	logic [31:0] u2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x;
			u_s2  <= 31'(({31'd0, x_s1} * {25'd0, HALF_PI_Q30}) >> 24);
			u2_s3 <= 32'(({33'd0, u_s2} * {33'd0, u_s2}) >> 30);
		end
	end

	// Per term registers: A holds the scaled product, B the estimated quotient,
	// C the corrected term and running sum.
	logic [31:0]        na   [COS_TERMS];
	logic [31:0]        u2a  [COS_TERMS];
	logic signed [32:0] sa   [COS_TERMS];
	logic [31:0]        nb   [COS_TERMS];
	logic [31:0]        q0b  [COS_TERMS];
	logic [31:0]        u2b  [COS_TERMS];
	logic signed [32:0] sb   [COS_TERMS];
	logic [31:0]        tc   [COS_TERMS];
	logic [31:0]        u2c  [COS_TERMS];
	logic signed [32:0] sc   [COS_TERMS];

	for (genvar k = 0; k < COS_TERMS; k++) begin : g_term
		localparam int DIVK = (2 * k + 1) * (2 * k + 2);
		localparam logic [31:0] RCP = 32'((64'd1 << 32) / DIVK);

		logic [31:0]        t_in, u2_in, r;
		logic signed [32:0] s_in;

		if (k == 0) begin : g_first
			assign t_in  = 32'd1 << 30;
			assign u2_in = u2_s3;
			assign s_in  = 33'sd1 << 30;
		end else begin : g_next
			assign t_in  = tc[k-1];
			assign u2_in = u2c[k-1];
			assign s_in  = sc[k-1];
		end

		// The estimate is low by at most one.
		assign r = nb[k] - 32'(q0b[k] * 32'(DIVK));

		always_ff @(posedge clk) begin
			if (en) begin
				na[k]  <= 32'(({32'd0, t_in} * {32'd0, u2_in}) >> 30);
				u2a[k] <= u2_in;
				sa[k]  <= s_in;
				nb[k]  <= na[k];
				q0b[k] <= 32'(({32'd0, na[k]} * {32'd0, RCP}) >> 32);
				u2b[k] <= u2a[k];
				sb[k]  <= sa[k];
				tc[k]  <= (r >= 32'(DIVK)) ? q0b[k] + 32'd1 : q0b[k];
				u2c[k] <= u2b[k];
				if (k % 2 == 0)
					sc[k] <= sb[k] - signed'({1'b0, ((r >= 32'(DIVK)) ? q0b[k] + 32'd1 : q0b[k])});
				else
					sc[k] <= sb[k] + signed'({1'b0, ((r >= 32'(DIVK)) ? q0b[k] + 32'd1 : q0b[k])});
			end
		end
	end

	logic [32:0]        s_pos;
	logic [24:0]        rnd;
	logic signed [25:0] c_s;

	always_comb begin
		s_pos = sc[COS_TERMS-1][32] ? 33'd0 : unsigned'(sc[COS_TERMS-1]);
		rnd   = 25'((s_pos + 33'd32) >> 6);
	end

	always_ff @(posedge clk) begin
		if (en)
			c_s <= neg_s[COS_STAGES-2] ? -signed'({1'b0, rnd}) : signed'({1'b0, rnd});
	end

	assign out_vld  = vld_s[COS_STAGES-1];
	assign out_item = item_s[COS_STAGES-1];
	assign out_c    = c_s;

endmodule

[rtl/morph_weight_easing.sv]
// Pipeline: 1 check stage, 10 divider stages, 22 cosine stages and 2 combine
// stages lie between request transfer and result valid.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits, set by the single output register and the shared stage enable.
// Reset: arst_n clears all valid bits and both configuration registers.
// ----------------------------------------------------------------------------
// morph_weight_easing
// Morph weights between two key frames with optional cosine easing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module morph_weight_easing import mwe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	mwe_req_if.sink  req,
	mwe_rsp_if.source rsp,
	mwe_cfg_if.sink  cfg
);

	logic en;
	assign en = !rsp.valid || rsp.ready;

	logic    vld_f;
	div_in_t din_f;

	mwe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (req),
		.cfg    (cfg),
		.vld_s1 (vld_f),
		.din_s1 (din_f)
	);

	logic        vld_d;
	meta_t       meta_d;
	logic [39:0] q1_d;
	logic [31:0] q2_d;

	mwe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_f),
		.din      (din_f),
		.out_vld  (vld_d),
		.out_meta (meta_d),
		.out_q1   (q1_d),
		.out_q2   (q2_d)
	);

	logic               vld_c;
	item_t              item_c;
	logic signed [25:0] c_c;

	mwe_cos u_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_d),
		.in_meta  (meta_d),
		.in_q1    (q1_d),
		.in_q2    (q2_d),
		.out_vld  (vld_c),
		.out_item (item_c),
		.out_c    (c_c)
	);

	localparam logic signed [41:0] ONE42 = 42'sd16777216;

	logic signed [41:0] vv;
	logic signed [41:0] c42;
	logic               vld_s1;
	meta_t              meta_s1;
	logic signed [43:0] wm_s1;

	always_comb begin
		c42 = 42'(c_c);
		case (item_c.meta.curve)
			CRV_TINY:  vv = (ONE42 - c42) >>> 1;
			CRV_LEAD:  vv = ONE42 - c42;
			CRV_TRAIL: vv = -c42;
			default:   vv = signed'({2'b00, item_c.v});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= vld_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= item_c.meta;
			wm_s1   <= item_c.meta.rev ? 44'(vv) - 44'(item_c.o) : 44'(vv) + 44'(item_c.o);
		end
	end

	logic signed [43:0] wo;
	logic [31:0]        sat_m, sat_o;

	always_comb begin
		wo    = 44'sd16777216 - wm_s1;
		sat_m = sat32(wm_s1);
		sat_o = sat32(wo);
	end

	logic               vld_s2;
	logic signed [31:0] wf_s2, wt_s2;
	logic [1:0]         curve_s2, status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	// Any error forces zero weights and no curve.
	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= meta_s1.status;
			if (meta_s1.status != ST_OK) begin
				wf_s2    <= 32'sd0;
				wt_s2    <= 32'sd0;
				curve_s2 <= CRV_NONE;
			end else begin
				wf_s2    <= meta_s1.rev ? sat_m : sat_o;
				wt_s2    <= meta_s1.rev ? sat_o : sat_m;
				curve_s2 <= meta_s1.curve;
			end
		end
	end

	assign rsp.valid       = vld_s2;
	assign rsp.weight_from = wf_s2;
	assign rsp.weight_to   = wt_s2;
	assign rsp.curve_used  = curve_s2;
	assign rsp.status      = status_s2;

	`MWE_ASSERT(a_err_zero, rsp.valid && rsp.status != ST_OK |-> rsp.weight_from == 32'sd0 && rsp.weight_to == 32'sd0 && rsp.curve_used == CRV_NONE, "error result carries non-zero fields")
	`MWE_ASSERT(a_status_code, rsp.valid |-> rsp.status == ST_OK || rsp.status == ST_NOCLIP || rsp.status == ST_ZERODUR, "undefined status code")
	`MWE_ASSERT(a_stall_hold, rsp.valid && !rsp.ready |-> !req.ready, "request taken while a result is stalled")
	`MWE_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !rsp.valid, "result valid during reset")

endmodule
